// File: src/quadratic_root_solver_core_macros.svh
// Assertion macros for the quadratic root solver.
`ifndef QUADRATIC_ROOT_SOLVER_CORE_MACROS_SVH
`define QUADRATIC_ROOT_SOLVER_CORE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define QRS_CHECK(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define QRS_CHECK_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: src/qrs_pkg.sv
// Types and constants shared by the quadratic root solver.
package qrs_pkg;
	localparam int CoefW = 16;
	localparam int OutW = 40;

	localparam logic [1:0] KIND_TWO_REAL = 2'd0;
	localparam logic [1:0] KIND_DOUBLE   = 2'd1;
	localparam logic [1:0] KIND_COMPLEX  = 2'd2;
	localparam logic [1:0] KIND_ERROR    = 2'd3;

	typedef struct packed {
		logic signed [CoefW-1:0] coef_a;
		logic signed [CoefW-1:0] coef_b;
		logic signed [CoefW-1:0] coef_c;
	} coef_t;

	typedef struct packed {
		logic [1:0]             root_kind;
		logic signed [OutW-1:0] first_real;
		logic signed [OutW-1:0] second_real;
		logic signed [OutW-1:0] first_imag;
		logic signed [OutW-1:0] second_imag;
	} roots_t;
endpackage

// File: src/qrs_sqrt.sv
// Pipelined restoring square root, one root bit per stage.
module qrs_sqrt #(
	parameter int NW = 68,
	parameter int SW = 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  logic [NW-1:0]     radicand,
	input  logic [SW-1:0]     in_side,
	output logic              out_valid,
	output logic [NW/2-1:0]   root,
	output logic [SW-1:0]     out_side
);
	localparam int RW = NW / 2;

	logic [RW:0]   rem_s  [RW+1];
	logic [RW-1:0] root_s [RW+1];
	logic [NW-1:0] rad_s  [RW+1];
	logic [SW-1:0] side_s [RW+1];
	logic          vld_s  [RW+1];

	assign rem_s[0]  = '0;
	assign root_s[0] = '0;
	assign rad_s[0]  = radicand;
	assign side_s[0] = in_side;
	assign vld_s[0]  = in_valid;

	for (genvar i = 0; i < RW; i++) begin : g_stage
		logic [RW+1:0] t;
		logic [RW+1:0] trial;
		logic [RW+1:0] diff;
		logic          ge;

		always_comb begin
			t     = {rem_s[i][RW-1:0], rad_s[i][NW-1 -: 2]};
			trial = {root_s[i], 2'b01};
			ge    = (t >= trial);
			diff  = t - trial;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else if (en) begin
				vld_s[i+1] <= vld_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i+1]  <= ge ? diff[RW:0] : t[RW:0];
				root_s[i+1] <= {root_s[i][RW-2:0], ge};
				rad_s[i+1]  <= rad_s[i] << 2;
				side_s[i+1] <= side_s[i];
			end
		end
	end

	assign out_valid = vld_s[RW];
	assign root      = root_s[RW];
	assign out_side  = side_s[RW];
endmodule

// File: src/qrs_div.sv
// Pipelined restoring unsigned divider, one quotient bit per stage.
module qrs_div #(
	parameter int NUMW = 36,
	parameter int DENW = 17,
	parameter int SW   = 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  logic [NUMW-1:0]   dividend,
	input  logic [DENW-1:0]   divisor,
	input  logic [SW-1:0]     in_side,
	output logic              out_valid,
	output logic [NUMW-1:0]   quotient,
	output logic [SW-1:0]     out_side
);
	logic [DENW-1:0] rem_s  [NUMW+1];
	logic [NUMW-1:0] dq_s   [NUMW+1];
	logic [DENW-1:0] dv_s   [NUMW+1];
	logic [SW-1:0]   side_s [NUMW+1];
	logic            vld_s  [NUMW+1];

	assign rem_s[0]  = '0;
	assign dq_s[0]   = dividend;
	assign dv_s[0]   = divisor;
	assign side_s[0] = in_side;
	assign vld_s[0]  = in_valid;

	for (genvar i = 0; i < NUMW; i++) begin : g_stage
		logic [DENW:0] t;
		logic [DENW:0] diff;
		logic          ge;

		always_comb begin
			t    = {rem_s[i], dq_s[i][NUMW-1]};
			ge   = (t >= {1'b0, dv_s[i]});
			diff = t - {1'b0, dv_s[i]};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else if (en) begin
				vld_s[i+1] <= vld_s[i];
			end
		end

		// dividend bits shift out at the top while quotient bits fill in below
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i+1]  <= ge ? diff[DENW-1:0] : t[DENW-1:0];
				dq_s[i+1]   <= {dq_s[i][NUMW-2:0], ge};
				dv_s[i+1]   <= dv_s[i];
				side_s[i+1] <= side_s[i];
			end
		end
	end

	assign out_valid = vld_s[NUMW];
	assign quotient  = dq_s[NUMW];
	assign out_side  = side_s[NUMW];
endmodule

// File: src/quadratic_root_solver_core.sv
// Top level of the pipelined quadratic root solver.
// Accepts one coefficient transaction per cycle and returns one root transaction for each,
// in order. The pipeline has one product stage, one discriminant stage, one square-root
// stage per root bit, one numerator stage, one divider stage per quotient bit and one
// saturating output register. The whole pipeline holds while a finished result waits
// on roots_ready.
module quadratic_root_solver_core #(
	parameter int FRAC_BITS = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           coef_valid,
	output logic           coef_ready,
	input  qrs_pkg::coef_t coef,
	output logic           roots_valid,
	input  logic           roots_ready,
	output qrs_pkg::roots_t roots
);
	import qrs_pkg::*;

	`include "quadratic_root_solver_core_macros.svh"

	localparam int PW   = 2 * CoefW;
	localparam int DW   = 2 * CoefW + 3;
	localparam int NW0  = DW + 2 * FRAC_BITS;
	localparam int NW   = NW0 + (NW0 % 2);
	localparam int RW   = NW / 2;
	localparam int NBW  = CoefW + 1 + FRAC_BITS;
	localparam int NUMW = ((NBW > RW + 1) ? NBW : RW + 1) + 1;
	localparam int DENW = CoefW + 1;
	localparam int VW   = NUMW + 1;
	localparam int CW2  = (VW > OutW) ? VW : OutW;
	localparam int SQSW = 2 + NBW + CoefW;

	logic en;
	assign en         = !roots_valid || roots_ready;
	assign coef_ready = en;

	// stage 1: products
	logic                    vld_s1;
	logic signed [CoefW-1:0] a_s1, b_s1;
	logic signed [PW-1:0]    bb_s1, ac_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= coef_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_s1  <= coef.coef_a;
			b_s1  <= coef.coef_b;
			bb_s1 <= coef.coef_b * coef.coef_b;
			ac_s1 <= coef.coef_a * coef.coef_c;
		end
	end

	// stage 2: discriminant, kind, scaled -b
	logic signed [DW-1:0]  d;
	logic [DW-1:0]         d_mag;
	logic [1:0]            kind;
	logic signed [NBW-1:0] bx, nb;

	always_comb begin
		d     = DW'(bb_s1) - (DW'(ac_s1) <<< 2);
		d_mag = d[DW-1] ? DW'(-d) : DW'(d);
		if (a_s1 == '0) begin
			kind = KIND_ERROR;
		end else if (d[DW-1]) begin
			kind = KIND_COMPLEX;
		end else if (d == '0) begin
			kind = KIND_DOUBLE;
		end else begin
			kind = KIND_TWO_REAL;
		end
		bx = NBW'(b_s1);
		nb = (-bx) <<< FRAC_BITS;
	end

	logic                    vld_s2;
	logic [NW-1:0]           rad_s2;
	logic [1:0]              kind_s2;
	logic signed [NBW-1:0]   nb_s2;
	logic signed [CoefW-1:0] a_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rad_s2  <= NW'(d_mag) << (2 * FRAC_BITS);
			kind_s2 <= kind;
			nb_s2   <= nb;
			a_s2    <= a_s1;
		end
	end

	// square root
	logic            sq_valid;
	logic [RW-1:0]   sq_root;
	logic [SQSW-1:0] sq_side;

	qrs_sqrt #(.NW(NW), .SW(SQSW)) u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (vld_s2),
		.radicand (rad_s2),
		.in_side  ({kind_s2, nb_s2, a_s2}),
		.out_valid(sq_valid),
		.root     (sq_root),
		.out_side (sq_side)
	);

	// stage 3: numerators and divisor magnitude
	logic [1:0]               sq_kind;
	logic signed [NBW-1:0]    sq_nb;
	logic signed [CoefW-1:0]  sq_a;
	logic signed [NUMW-1:0]   nbw, rw, n1, n2;
	logic signed [DENW-1:0]   den;
	logic [NUMW-1:0]          n1_mag, n2_mag;
	logic [DENW-1:0]          den_mag;

	always_comb begin
		{sq_kind, sq_nb, sq_a} = sq_side;
		nbw = NUMW'(sq_nb);
		rw  = NUMW'({1'b0, sq_root});
		if (sq_kind == KIND_TWO_REAL) begin
			n1 = nbw + rw;
			n2 = nbw - rw;
		end else begin
			// double, complex and error: real part from -b alone, imaginary from the root
			n1 = nbw;
			n2 = rw;
		end
		den     = DENW'(sq_a) <<< 1;
		n1_mag  = n1[NUMW-1] ? NUMW'(-n1) : NUMW'(n1);
		n2_mag  = n2[NUMW-1] ? NUMW'(-n2) : NUMW'(n2);
		den_mag = den[DENW-1] ? DENW'(-den) : DENW'(den);
	end

	logic            vld_s3;
	logic [NUMW-1:0] n1_s3, n2_s3;
	logic [DENW-1:0] den_s3;
	logic [1:0]      kind_s3;
	logic            sg1_s3, sg2_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s3 <= sq_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			n1_s3   <= n1_mag;
			n2_s3   <= n2_mag;
			den_s3  <= den_mag;
			kind_s3 <= sq_kind;
			sg1_s3  <= n1[NUMW-1] ^ sq_a[CoefW-1];
			sg2_s3  <= n2[NUMW-1] ^ sq_a[CoefW-1];
		end
	end

	// dividers
	logic            d1_valid, d2_valid;
	logic [NUMW-1:0] q1, q2;
	logic [2:0]      d1_side;
	logic            d2_side;

	qrs_div #(.NUMW(NUMW), .DENW(DENW), .SW(3)) u_div_first (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (vld_s3),
		.dividend (n1_s3),
		.divisor  (den_s3),
		.in_side  ({kind_s3, sg1_s3}),
		.out_valid(d1_valid),
		.quotient (q1),
		.out_side (d1_side)
	);

	qrs_div #(.NUMW(NUMW), .DENW(DENW), .SW(1)) u_div_second (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (vld_s3),
		.dividend (n2_s3),
		.divisor  (den_s3),
		.in_side  (sg2_s3),
		.out_valid(d2_valid),
		.quotient (q2),
		.out_side (d2_side)
	);

	// stage 4: sign, saturation, result
	function automatic logic signed [OutW-1:0] sat(input logic signed [VW-1:0] v);
		logic signed [CW2-1:0] vx;
		logic signed [CW2-1:0] hi;
		logic signed [CW2-1:0] lo;
		vx = CW2'(v);
		hi = {{(CW2-OutW+1){1'b0}}, {(OutW-1){1'b1}}};
		lo = {{(CW2-OutW+1){1'b1}}, {(OutW-1){1'b0}}};
		if (vx > hi) begin
			vx = hi;
		end else if (vx < lo) begin
			vx = lo;
		end
		return vx[OutW-1:0];
	endfunction

	logic [1:0]           res_kind;
	logic signed [VW-1:0] v1, v2;
	roots_t               res;

	always_comb begin
		res_kind = d1_side[2:1];
		v1 = d1_side[0] ? -$signed({1'b0, q1}) : $signed({1'b0, q1});
		v2 = d2_side ? -$signed({1'b0, q2}) : $signed({1'b0, q2});
		res = '0;
		res.root_kind = res_kind;
		case (res_kind)
			KIND_TWO_REAL: begin
				res.first_real  = sat(v1);
				res.second_real = sat(v2);
			end
			KIND_DOUBLE: begin
				res.first_real  = sat(v1);
				res.second_real = sat(v1);
			end
			KIND_COMPLEX: begin
				res.first_real  = sat(v1);
				res.second_real = sat(v1);
				res.first_imag  = sat(v2);
				res.second_imag = sat(-v2);
			end
			default: begin
			end
		endcase
	end

	logic   vld_s4;
	roots_t res_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s4 <= d1_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_s4 <= res;
		end
	end

	assign roots_valid = vld_s4;
	assign roots       = res_s4;

	`QRS_CHECK(a_lanes_in_step, 1'b1, d1_valid == d2_valid, "divider lanes out of step")
	`QRS_CHECK(a_error_zero, roots_valid && roots.root_kind == KIND_ERROR,
		roots.first_real == '0 && roots.second_real == '0 && roots.first_imag == '0
		&& roots.second_imag == '0, "error result carries nonzero roots")
	`QRS_CHECK(a_real_no_imag, roots_valid && (roots.root_kind == KIND_TWO_REAL
		|| roots.root_kind == KIND_DOUBLE),
		roots.first_imag == '0 && roots.second_imag == '0, "real roots with imaginary part")
	`QRS_CHECK_NEXT(a_stall_holds, roots_valid && !roots_ready,
		roots_valid && $stable(roots) && $stable(vld_s3), "stall moved the pipeline")
endmodule

// File: sim/qrs_checker.sv
// Checker for the quadratic root solver: predicts roots and compares each result transaction.
`timescale 1ns / 100ps
module qrs_checker (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            coef_valid,
	input  logic            coef_ready,
	input  qrs_pkg::coef_t  coef,
	input  logic            roots_valid,
	input  logic            roots_ready,
	input  qrs_pkg::roots_t roots,
	output int              fail_count,
	output int              pending
);
	import qrs_pkg::*;

	localparam int FracBits = 16;
	localparam logic signed [63:0] RootMax = 64'sd549755813887;
	localparam logic signed [63:0] RootMin = -64'sd549755813888;

	roots_t roots_due[$];

	function automatic logic [OutW-1:0] clamp_root(input logic signed [63:0] v);
		if (v > RootMax)
			return RootMax[OutW-1:0];
		if (v < RootMin)
			return RootMin[OutW-1:0];
		return v[OutW-1:0];
	endfunction

	// floor(sqrt(n)) bit by bit, n up to 128 bits
	function automatic logic [63:0] floor_sqrt(input logic [127:0] n);
		logic [63:0] r;
		logic [63:0] trial;
		r = '0;
		for (int k = 63; k >= 0; k--) begin
			trial = r | (64'd1 << k);
			if ({64'd0, trial} * {64'd0, trial} <= n)
				r = trial;
		end
		return r;
	endfunction

	function automatic roots_t solve_roots(input coef_t cf);
		roots_t res;
		logic signed [63:0] a, b, c, disc, den, negb, r;
		logic [63:0] mag;
		a = cf.coef_a;
		b = cf.coef_b;
		c = cf.coef_c;
		res = '0;
		if (a == 0) begin
			res.root_kind = KIND_ERROR;
			return res;
		end
		disc = b * b - 64'sd4 * a * c;
		mag = (disc < 0) ? -disc : disc;
		r = $signed(floor_sqrt({64'd0, mag} << (2 * FracBits)));
		den = 64'sd2 * a;
		negb = -b * (64'sd1 <<< FracBits);
		if (disc > 0) begin
			res.root_kind = KIND_TWO_REAL;
			res.first_real = clamp_root((negb + r) / den);
			res.second_real = clamp_root((negb - r) / den);
		end else if (disc == 0) begin
			res.root_kind = KIND_DOUBLE;
			res.first_real = clamp_root(negb / den);
			res.second_real = res.first_real;
		end else begin
			res.root_kind = KIND_COMPLEX;
			res.first_real = clamp_root(negb / den);
			res.second_real = res.first_real;
			res.first_imag = clamp_root(r / den);
			res.second_imag = clamp_root(-(r / den));
		end
		return res;
	endfunction

	assign pending = roots_due.size();

	always @(posedge clk or negedge arst_n) begin
		roots_t want;
		if (!arst_n) begin
			fail_count <= 0;
		end else begin
			if (coef_valid && coef_ready)
				roots_due.push_back(solve_roots(coef));
			if (roots_valid && roots_ready) begin
				if (roots_due.size() == 0) begin
					$error("unexpected roots transaction");
					fail_count <= fail_count + 1;
				end else begin
					want = roots_due.pop_front();
					if (roots !== want) begin
						fail_count <= fail_count + 1;
						if (roots.root_kind !== want.root_kind)
							$error("root_kind exp %0d got %0d", want.root_kind, roots.root_kind);
						if (roots.first_real !== want.first_real)
							$error("first_real exp %0d got %0d", want.first_real, roots.first_real);
						if (roots.second_real !== want.second_real)
							$error("second_real exp %0d got %0d", want.second_real,
								roots.second_real);
						if (roots.first_imag !== want.first_imag)
							$error("first_imag exp %0d got %0d", want.first_imag, roots.first_imag);
						if (roots.second_imag !== want.second_imag)
							$error("second_imag exp %0d got %0d", want.second_imag,
								roots.second_imag);
					end
				end
			end
		end
	end
endmodule

// File: sim/tb.sv
// Stimulus and verdict for the quadratic root solver.
`timescale 1ns / 100ps
module tb;
	import qrs_pkg::*;

	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	logic    coef_valid = 1'b0;
	logic    coef_ready;
	coef_t   coef = '0;
	logic    roots_valid;
	logic    roots_ready = 1'b0;
	roots_t  roots;
	int      fail_count;
	int      pending;
	int      send_idle_pct = 0;
	int      recv_idle_pct = 0;
	bit      recv_hold = 1'b0;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	quadratic_root_solver_core u_top (
		.clk(clk), .arst_n(arst_n), .coef_valid(coef_valid), .coef_ready(coef_ready),
		.coef(coef), .roots_valid(roots_valid), .roots_ready(roots_ready), .roots(roots)
	);

	qrs_checker u_checker (
		.clk(clk), .arst_n(arst_n), .coef_valid(coef_valid), .coef_ready(coef_ready),
		.coef(coef), .roots_valid(roots_valid), .roots_ready(roots_ready), .roots(roots),
		.fail_count(fail_count), .pending(pending)
	);

	always @(posedge clk) begin
		if (arst_n)
			roots_ready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
	end

	// one transaction, with random idle cycles first; valid stays up between
	// back-to-back transactions
	task automatic send_coef(input coef_t cf);
		if ($urandom_range(99) < send_idle_pct) begin
			coef_valid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(99) < send_idle_pct);
		end
		coef_valid <= 1'b1;
		coef <= cf;
		do
			@(posedge clk);
		while (!coef_ready);
	endtask

	function automatic logic signed [15:0] pick_coef();
		case ($urandom_range(5))
			0: return 16'sh7fff;
			1: return 16'sh8000;
			2: return 16'($signed($urandom_range(15)) - 8);
			3: return 16'($signed($urandom_range(400)) - 200);
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic send_random(input int count);
		coef_t cf;
		int k;
		for (int i = 0; i < count; i++) begin
			cf.coef_a = pick_coef();
			cf.coef_b = pick_coef();
			cf.coef_c = pick_coef();
			// some perfect squares so the double root turns up: b = 2ak, c = ak^2
			if ($urandom_range(7) == 0) begin
				cf.coef_a = 16'($signed($urandom_range(40)) - 20);
				k = $signed($urandom_range(40)) - 20;
				cf.coef_b = 16'(2 * cf.coef_a * k);
				cf.coef_c = 16'(cf.coef_a * k * k);
			end
			send_coef(cf);
		end
	endtask

	task automatic drain();
		coef_valid <= 1'b0;
		while (pending != 0)
			@(posedge clk);
	endtask

	initial begin
		#2000000;
		$display("tb: done, errors");
		$finish;
	end

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_coef('{16'sd1, -16'sd3, 16'sd2});
		send_coef('{16'sd1, 16'sd2, 16'sd1});
		send_coef('{16'sd1, 16'sd0, 16'sd1});
		send_coef('{16'sd0, 16'sd5, 16'sd7});
		send_coef('{16'sd0, 16'sd0, 16'sd0});
		send_coef('{-16'sd1, 16'sd0, -16'sd4});
		send_coef('{-16'sd2, 16'sd3, 16'sd5});
		send_coef('{16'sh7fff, 16'sh7fff, 16'sh7fff});
		send_coef('{16'sh8000, 16'sh8000, 16'sh8000});
		send_coef('{16'sh7fff, 16'sh8000, 16'sh8000});
		send_coef('{16'sh8000, 16'sh7fff, 16'sh7fff});
		send_coef('{16'sh8000, 16'sh0000, 16'sh7fff});
		send_coef('{16'sh7fff, 16'sh0000, 16'sh8000});
		send_coef('{16'sh0001, 16'sh8000, 16'sh0000});
		send_coef('{-16'sd1, 16'sd0, 16'sd0});
		send_coef('{16'sd3, 16'sd12, 16'sd12});
		send_coef('{16'shffff, 16'shffff, 16'shffff});
		send_coef('{16'sh5555, 16'shaaaa, 16'sh5555});
		// hold the receiver long enough for the pipeline to fill and stall
		recv_hold = 1'b1;
		fork
			begin
				repeat (300) @(posedge clk);
				recv_hold = 1'b0;
			end
			send_random(150);
		join
		drain();
		send_idle_pct = 30;
		recv_idle_pct = 56;
		send_random(450);
		send_idle_pct = 56;
		recv_idle_pct = 30;
		send_random(450);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		send_random(450);
		drain();
		repeat (100) @(posedge clk);
		if (fail_count == 0)
			$display("tb: done, clean");
		else
			$display("tb: done, errors");
		$finish;
	end
endmodule
